// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/mdfs_pkg.sv =====
`timescale 1ns / 1ps

package mdfs_pkg;

    localparam int INNER_ROWS_DEF  = 14;
    localparam int INNER_COLS_DEF  = 14;
    localparam int STACK_DEPTH_DEF = 256;

    localparam int COORD_W = 4;
    localparam int DIR_W   = 4;
    localparam int CNT_W   = 9;
    localparam int IDX_W   = 8;
    localparam int CELL_W  = 2 * COORD_W;
    localparam int PC_W    = 5;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               wall;
        logic [IDX_W-1:0]   entry_index;
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic [CNT_W-1:0]   path_length;
        logic [COORD_W-1:0] path_row;
        logic [COORD_W-1:0] path_col;
        logic               entry_valid;
    } t_res;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIR_W-1:0]   dir;
    } t_stk_entry;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLRV,
        ACT_CLRALL,
        ACT_INIT,
        ACT_PUSH,
        ACT_POP,
        ACT_LOAD,
        ACT_PROBE,
        ACT_ADVANCE,
        ACT_STEPD,
        ACT_PUSHGOAL,
        ACT_FAIL,
        ACT_WRCELL,
        ACT_RDENT,
        ACT_FINISH
    } t_act;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_CLR_MORE,
        C_SP_ZERO,
        C_D_END,
        C_GOAL,
        C_BLOCKED,
        C_FULL
    } t_cond;

    typedef struct packed {
        t_act            act;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            halt;
    } t_uword;

    // Microprogram step addresses.
    localparam logic [PC_W-1:0] S_CLRV     = 5'd0;
    localparam logic [PC_W-1:0] S_INIT     = 5'd1;
    localparam logic [PC_W-1:0] S_PUSH0    = 5'd2;
    localparam logic [PC_W-1:0] S_POPCHK   = 5'd3;
    localparam logic [PC_W-1:0] S_POP      = 5'd4;
    localparam logic [PC_W-1:0] S_LOAD     = 5'd5;
    localparam logic [PC_W-1:0] S_DIRCHK   = 5'd6;
    localparam logic [PC_W-1:0] S_PROBE    = 5'd7;
    localparam logic [PC_W-1:0] S_CHECK    = 5'd8;
    localparam logic [PC_W-1:0] S_ADVCHK   = 5'd9;
    localparam logic [PC_W-1:0] S_ADVANCE  = 5'd10;
    localparam logic [PC_W-1:0] S_STEPD    = 5'd11;
    localparam logic [PC_W-1:0] S_GOALCHK1 = 5'd12;
    localparam logic [PC_W-1:0] S_GOALPSH1 = 5'd13;
    localparam logic [PC_W-1:0] S_GOALCHK2 = 5'd14;
    localparam logic [PC_W-1:0] S_GOALPSH2 = 5'd15;
    localparam logic [PC_W-1:0] S_FAIL     = 5'd16;
    localparam logic [PC_W-1:0] S_END      = 5'd17;
    localparam logic [PC_W-1:0] S_WRITE    = 5'd18;
    localparam logic [PC_W-1:0] S_RD       = 5'd19;
    localparam logic [PC_W-1:0] S_RSTCLR   = 5'd20;
    localparam logic [PC_W-1:0] S_RSTDONE  = 5'd21;

    // Control store. A step whose condition holds jumps to its target,
    // otherwise it falls through; the action is carried out either way.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        uw = '{act: ACT_NONE, cond: C_NEVER, target: S_END, halt: 1'b1};
        unique case (pc)
            S_CLRV:     uw = '{act: ACT_CLRV, cond: C_CLR_MORE, target: S_CLRV, halt: 1'b0};
            S_INIT:     uw = '{act: ACT_INIT, cond: C_NEVER, target: S_END, halt: 1'b0};
            S_PUSH0:    uw = '{act: ACT_PUSH, cond: C_NEVER, target: S_END, halt: 1'b0};
            S_POPCHK:   uw = '{act: ACT_NONE, cond: C_SP_ZERO, target: S_END, halt: 1'b0};
            S_POP:      uw = '{act: ACT_POP, cond: C_NEVER, target: S_END, halt: 1'b0};
            S_LOAD:     uw = '{act: ACT_LOAD, cond: C_NEVER, target: S_END, halt: 1'b0};
            S_DIRCHK:   uw = '{act: ACT_NONE, cond: C_D_END, target: S_POPCHK, halt: 1'b0};
            S_PROBE:    uw = '{act: ACT_PROBE, cond: C_GOAL, target: S_GOALCHK1, halt: 1'b0};
            S_CHECK:    uw = '{act: ACT_NONE, cond: C_BLOCKED, target: S_STEPD, halt: 1'b0};
            S_ADVCHK:   uw = '{act: ACT_NONE, cond: C_FULL, target: S_FAIL, halt: 1'b0};
            S_ADVANCE:  uw = '{act: ACT_ADVANCE, cond: C_ALWAYS, target: S_DIRCHK,
                               halt: 1'b0};
            S_STEPD:    uw = '{act: ACT_STEPD, cond: C_ALWAYS, target: S_DIRCHK, halt: 1'b0};
            S_GOALCHK1: uw = '{act: ACT_NONE, cond: C_FULL, target: S_FAIL, halt: 1'b0};
            S_GOALPSH1: uw = '{act: ACT_PUSH, cond: C_NEVER, target: S_END, halt: 1'b0};
            S_GOALCHK2: uw = '{act: ACT_NONE, cond: C_FULL, target: S_FAIL, halt: 1'b0};
            S_GOALPSH2: uw = '{act: ACT_PUSHGOAL, cond: C_ALWAYS, target: S_END,
                               halt: 1'b0};
            S_FAIL:     uw = '{act: ACT_FAIL, cond: C_NEVER, target: S_END, halt: 1'b0};
            S_END:      uw = '{act: ACT_FINISH, cond: C_NEVER, target: S_END, halt: 1'b1};
            S_WRITE:    uw = '{act: ACT_WRCELL, cond: C_ALWAYS, target: S_END, halt: 1'b0};
            S_RD:       uw = '{act: ACT_RDENT, cond: C_ALWAYS, target: S_END, halt: 1'b0};
            S_RSTCLR:   uw = '{act: ACT_CLRALL, cond: C_CLR_MORE, target: S_RSTCLR,
                               halt: 1'b0};
            S_RSTDONE:  uw = '{act: ACT_NONE, cond: C_NEVER, target: S_END, halt: 1'b1};
            default:    uw = '{act: ACT_NONE, cond: C_NEVER, target: S_END, halt: 1'b1};
        endcase
        return uw;
    endfunction

    // Row offsets of the eight directions, two's complement.
    function automatic logic [COORD_W-1:0] dir_dr(input logic [2:0] d);
        logic [COORD_W-1:0] v;
        v = '0;
        unique case (d)
            3'd0, 3'd1, 3'd4: v = 4'd1;
            3'd2, 3'd6:       v = 4'd0;
            default:          v = 4'hF;
        endcase
        return v;
    endfunction

    // Column offsets of the eight directions, two's complement.
    function automatic logic [COORD_W-1:0] dir_dc(input logic [2:0] d);
        logic [COORD_W-1:0] v;
        v = '0;
        unique case (d)
            3'd0, 3'd2, 3'd3: v = 4'd1;
            3'd1, 3'd5:       v = 4'd0;
            default:          v = 4'hF;
        endcase
        return v;
    endfunction

endpackage

// ===== design/maze_path_depth_first_search.sv =====
`timescale 1ns / 1ps

// Maze solver by depth-first search over eight directions, run by a small
// microprogram. Load cells with write items, start a search with a search item,
// then fetch the path one entry at a time with read items. Each item gives one
// result on o_res, flagged by o_valid high for exactly one cycle; the block
// cannot be stalled, so the receiver must take it then. A search first sweeps
// the visited marks clear and seeds the stack, then handles each pop, each
// blocked direction and each direction that advances as its own step sequence,
// and then finishes: the single-port maze and visited memories allow one probe
// per step sequence. After reset the block clears both memories with busy high.
module maze_path_depth_first_search #(
    parameter int INNER_ROWS  = mdfs_pkg::INNER_ROWS_DEF,
    parameter int INNER_COLS  = mdfs_pkg::INNER_COLS_DEF,
    parameter int STACK_DEPTH = mdfs_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mdfs_pkg::t_cmd i_cmd,
    output logic           busy,
    output logic           o_valid,
    output mdfs_pkg::t_res o_res
);
    import mdfs_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);

    // Control registers.
    logic               r_busy;
    logic [PC_W-1:0]    r_pc;
    logic [CNT_W-1:0]   r_sp;
    logic               r_found;
    logic               r_rdv;
    logic [CELL_W-1:0]  r_clr;
    logic               r_valid;

    // Datapath registers.
    t_cmd               r_cmd;
    logic [COORD_W-1:0] r_r;
    logic [COORD_W-1:0] r_c;
    logic [DIR_W-1:0]   r_d;
    logic [COORD_W-1:0] r_nr;
    logic [COORD_W-1:0] r_nc;
    t_res               r_res;

    // Memories and their registered read data.
    logic               r_maze [256];
    logic               r_vis [256];
    t_stk_entry         r_stk [STACK_DEPTH];
    logic               r_maze_q;
    logic               r_vis_q;
    t_stk_entry         r_stk_q;

    t_uword             uw;
    logic [COORD_W-1:0] nr_c;
    logic [COORD_W-1:0] nc_c;
    logic               goal_c;
    logic               inner_c;
    logic               blocked_c;
    logic               full_c;
    logic               cond_c;
    logic [PC_W-1:0]    entry_pc;

    logic               maze_we;
    logic [CELL_W-1:0]  maze_wa;
    logic               maze_wd;
    logic               vis_we;
    logic [CELL_W-1:0]  vis_wa;
    logic               vis_wd;
    logic               stk_we;
    logic [SW-1:0]      stk_wa;
    t_stk_entry         stk_wd;
    logic               stk_re;
    logic [SW-1:0]      stk_ra;
    logic [CNT_W-1:0]   sp_dec;

    assign uw     = ucode(r_pc);
    assign nr_c   = r_r + dir_dr(r_d[2:0]);
    assign nc_c   = r_c + dir_dc(r_d[2:0]);
    assign goal_c = (nr_c == COORD_W'(INNER_ROWS)) && (nc_c == COORD_W'(INNER_COLS));
    assign inner_c = (r_nr != '0) && (r_nr <= COORD_W'(INNER_ROWS)) &&
                     (r_nc != '0) && (r_nc <= COORD_W'(INNER_COLS));
    assign blocked_c = !inner_c || r_maze_q || r_vis_q;
    assign full_c    = r_sp >= CNT_W'(STACK_DEPTH);
    assign sp_dec    = r_sp - CNT_W'(1);

    always_comb begin
        case (uw.cond)
            C_NEVER:    cond_c = 1'b0;
            C_ALWAYS:   cond_c = 1'b1;
            C_CLR_MORE: cond_c = (r_clr != '1);
            C_SP_ZERO:  cond_c = (r_sp == '0);
            C_D_END:    cond_c = r_d[DIR_W-1];
            C_GOAL:     cond_c = goal_c;
            C_BLOCKED:  cond_c = blocked_c;
            C_FULL:     cond_c = full_c;
            default:    cond_c = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.func)
            FUNC_WRITE:  entry_pc = S_WRITE;
            FUNC_SEARCH: entry_pc = S_CLRV;
            FUNC_READ:   entry_pc = S_RD;
            default:     entry_pc = S_END;
        endcase
    end

    // Write port selection for the three memories and read port selection for the stack.
    always_comb begin
        maze_we = 1'b0;
        maze_wa = {r_cmd.cell_row, r_cmd.cell_col};
        maze_wd = r_cmd.wall;
        vis_we  = 1'b0;
        vis_wa  = r_clr;
        vis_wd  = 1'b0;
        stk_we  = 1'b0;
        stk_wa  = r_sp[SW-1:0];
        stk_wd  = '{row: r_r, col: r_c, dir: r_d};
        stk_re  = 1'b0;
        stk_ra  = sp_dec[SW-1:0];
        case (uw.act)
            ACT_CLRV: begin
                vis_we = 1'b1;
            end
            ACT_CLRALL: begin
                vis_we  = 1'b1;
                maze_we = 1'b1;
                maze_wa = r_clr;
                maze_wd = 1'b0;
            end
            ACT_INIT: begin
                vis_we = 1'b1;
                vis_wa = {COORD_W'(1), COORD_W'(1)};
                vis_wd = 1'b1;
            end
            ACT_PUSH: begin
                stk_we = 1'b1;
            end
            ACT_POP: begin
                stk_re = 1'b1;
            end
            ACT_ADVANCE: begin
                vis_we = 1'b1;
                vis_wa = {r_nr, r_nc};
                vis_wd = 1'b1;
                stk_we = 1'b1;
                stk_wd = '{row: r_r, col: r_c, dir: r_d + DIR_W'(1)};
            end
            ACT_PUSHGOAL: begin
                stk_we = 1'b1;
                stk_wd = '{row: r_nr, col: r_nc, dir: r_d};
            end
            ACT_WRCELL: begin
                maze_we = 1'b1;
            end
            ACT_RDENT: begin
                stk_re = 1'b1;
                stk_ra = r_cmd.entry_index[SW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (maze_we) begin
            r_maze[maze_wa] <= maze_wd;
        end
        if (uw.act == ACT_PROBE) begin
            r_maze_q <= r_maze[{nr_c, nc_c}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis[vis_wa] <= vis_wd;
        end
        if (uw.act == ACT_PROBE) begin
            r_vis_q <= r_vis[{nr_c, nc_c}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_q <= r_stk[stk_ra];
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_pc    <= S_RSTCLR;
            r_sp    <= '0;
            r_found <= 1'b0;
            r_rdv   <= 1'b0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (!r_busy) begin
                if (start) begin
                    r_busy <= 1'b1;
                    r_pc   <= entry_pc;
                    r_rdv  <= 1'b0;
                end
            end else begin
                if (uw.halt) begin
                    r_busy <= 1'b0;
                end else if (cond_c) begin
                    r_pc <= uw.target;
                end else begin
                    r_pc <= r_pc + PC_W'(1);
                end
                case (uw.act)
                    ACT_CLRV, ACT_CLRALL: r_clr <= r_clr + CELL_W'(1);
                    ACT_INIT: begin
                        r_sp    <= '0;
                        r_found <= 1'b0;
                    end
                    ACT_PUSH, ACT_ADVANCE: r_sp <= r_sp + CNT_W'(1);
                    ACT_POP:  r_sp <= sp_dec;
                    ACT_PUSHGOAL: begin
                        r_sp    <= r_sp + CNT_W'(1);
                        r_found <= 1'b1;
                    end
                    ACT_FAIL:   r_sp <= '0;
                    ACT_RDENT:  r_rdv <= ({1'b0, r_cmd.entry_index} < r_sp);
                    ACT_FINISH: r_valid <= 1'b1;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (!r_busy && start) begin
            r_cmd <= i_cmd;
        end
        if (r_busy) begin
            case (uw.act)
                ACT_INIT: begin
                    r_r <= COORD_W'(1);
                    r_c <= COORD_W'(1);
                    r_d <= '0;
                end
                ACT_LOAD: begin
                    r_r <= r_stk_q.row;
                    r_c <= r_stk_q.col;
                    r_d <= r_stk_q.dir;
                end
                ACT_PROBE: begin
                    r_nr <= nr_c;
                    r_nc <= nc_c;
                end
                ACT_ADVANCE: begin
                    r_r <= r_nr;
                    r_c <= r_nc;
                    r_d <= '0;
                end
                ACT_STEPD: r_d <= r_d + DIR_W'(1);
                ACT_FINISH: begin
                    r_res.found       <= r_found;
                    r_res.path_length <= r_sp;
                    r_res.path_row    <= r_rdv ? r_stk_q.row : '0;
                    r_res.path_col    <= r_rdv ? r_stk_q.col : '0;
                    r_res.entry_valid <= r_rdv;
                end
                default: begin
                end
            endcase
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_result_when_idle, o_valid, !busy)
    `ASSERT_NEXT(a_accept_starts_work, start && !busy, busy)
    `ASSERT_IMPL(a_stack_bounded, 1'b1, r_sp <= CNT_W'(STACK_DEPTH))
    `ASSERT_IMPL(a_found_has_path, r_found, r_sp >= CNT_W'(2))

endmodule
